### design/bprd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bprd_pkg
// Shared widths and beat layouts for the box pair distance core.
// ----------------------------------------------------------------------------
package bprd_pkg;

    localparam int DEF_COORD_BITS = 32;
    localparam int FIELD_BITS     = 32;
    localparam int DIST_BITS      = 33;
    localparam int SQ_BITS        = 66;
    localparam int SQ_SUM_BITS    = 67;
    localparam int ROOT_BITS      = 34;
    localparam int IN_BITS        = 8 * FIELD_BITS;
    localparam int OUT_BITS       = 2 * 1 + 2 * DIST_BITS + 4 * FIELD_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Side data carried beside the distance math.
    typedef struct packed {
        logic                         overlaps;
        logic                         first_holds_second;
        logic signed [FIELD_BITS-1:0] union_low_x;
        logic signed [FIELD_BITS-1:0] union_low_y;
        logic signed [FIELD_BITS-1:0] union_high_x;
        logic signed [FIELD_BITS-1:0] union_high_y;
    } side_t;

endpackage : bprd_pkg
`default_nettype wire

### design/box_pair_relation_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_pair_relation_distance_core
// Overlap, containment, min/max distance and union of two boxes.
// ----------------------------------------------------------------------------
// One box pair per cycle while the output is not stalled; the front stages (compare,
// square, sum), then 11 square-root stages of three result bits each, then the output
// register. Throughput is set by the fully pipelined root chain.
module box_pair_relation_distance_core
    import bprd_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_low_x, first_low_y, first_high_x, first_high_y,
    // second_low_x, second_low_y, second_high_x, second_high_y
    input  wire logic [IN_BITS-1:0]        s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // overlaps, first_holds_second, min_gap, max_span,
    // union_low_x, union_low_y, union_high_x, union_high_y, zero pad
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata
);

    localparam int STEPS  = 3;
    localparam int NSTAGE = (ROOT_BITS - 1 + STEPS - 1) / STEPS;

    logic en;
    logic                   v  [NSTAGE+1];
    logic [SQ_SUM_BITS-1:0] ra [NSTAGE+1];
    logic [SQ_SUM_BITS-1:0] rb [NSTAGE+1];
    logic [ROOT_BITS-1:0]   qa [NSTAGE+1];
    logic [ROOT_BITS-1:0]   qb [NSTAGE+1];
    side_t                  sd [NSTAGE+1];

    logic                   out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;

    // advance whenever the output slot is free or being drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    bprd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .out_valid   (v[0]),
        .out_gap_sq  (ra[0]),
        .out_span_sq (rb[0]),
        .out_side    (sd[0])
    );
    assign qa[0] = '0;
    assign qb[0] = '0;

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_root
        bprd_sqrt_stage #(.STEP_HI(ROOT_BITS - 2 - g * STEPS), .STEPS(STEPS)) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (v[g]),
            .in_rem_a   (ra[g]),
            .in_root_a  (qa[g]),
            .in_rem_b   (rb[g]),
            .in_root_b  (qb[g]),
            .in_side    (sd[g]),
            .out_valid  (v[g+1]),
            .out_rem_a  (ra[g+1]),
            .out_root_a (qa[g+1]),
            .out_rem_b  (rb[g+1]),
            .out_root_b (qb[g+1]),
            .out_side   (sd[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v[NSTAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= OUT_TDATA_BITS'({
                sd[NSTAGE].union_high_y, sd[NSTAGE].union_high_x,
                sd[NSTAGE].union_low_y,  sd[NSTAGE].union_low_x,
                qb[NSTAGE][DIST_BITS-1:0], qa[NSTAGE][DIST_BITS-1:0],
                sd[NSTAGE].first_holds_second, sd[NSTAGE].overlaps});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped under stall");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed under stall");
    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[34:2] == '0)
        else $error("overlapping boxes with nonzero gap");

endmodule : box_pair_relation_distance_core
`default_nettype wire

### design/bprd_sqrt_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bprd_sqrt_stage
// One registered step of a restoring square root: settles a group of
// result bits on two radicands in flight.
// ----------------------------------------------------------------------------
module bprd_sqrt_stage
    import bprd_pkg::*;
#(
    parameter int STEP_HI = 32,
    parameter int STEPS   = 3
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [SQ_SUM_BITS-1:0] in_rem_a,
    input  wire logic [ROOT_BITS-1:0]   in_root_a,
    input  wire logic [SQ_SUM_BITS-1:0] in_rem_b,
    input  wire logic [ROOT_BITS-1:0]   in_root_b,
    input  wire side_t                  in_side,
    output logic                        out_valid,
    output logic [SQ_SUM_BITS-1:0]      out_rem_a,
    output logic [ROOT_BITS-1:0]        out_root_a,
    output logic [SQ_SUM_BITS-1:0]      out_rem_b,
    output logic [ROOT_BITS-1:0]        out_root_b,
    output side_t                       out_side
);

    localparam int W = SQ_SUM_BITS + 2;

    logic                   valid_reg;
    logic [SQ_SUM_BITS-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [ROOT_BITS-1:0]   root_a_reg, root_a_next, root_b_reg, root_b_next;
    side_t                  side_reg;

    // Remainder form: rem = N - r^2; try bit b: need 2*r*2^b + 2^(2b) <= rem.
    always_comb
    begin
        logic [W-1:0] trial;
        rem_a_next  = in_rem_a;
        root_a_next = in_root_a;
        rem_b_next  = in_rem_b;
        root_b_next = in_root_b;
        for (int i = 0; i < STEPS; i++)
        begin
            if (STEP_HI - i >= 0)
            begin
                trial = (W'(root_a_next) << (STEP_HI - i + 1))
                      + (W'(1) << (2 * (STEP_HI - i)));
                if (trial <= W'(rem_a_next))
                begin
                    rem_a_next  = rem_a_next - SQ_SUM_BITS'(trial);
                    root_a_next = root_a_next | (ROOT_BITS'(1) << (STEP_HI - i));
                end
                trial = (W'(root_b_next) << (STEP_HI - i + 1))
                      + (W'(1) << (2 * (STEP_HI - i)));
                if (trial <= W'(rem_b_next))
                begin
                    rem_b_next  = rem_b_next - SQ_SUM_BITS'(trial);
                    root_b_next = root_b_next | (ROOT_BITS'(1) << (STEP_HI - i));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a_reg  <= rem_a_next;
            root_a_reg <= root_a_next;
            rem_b_reg  <= rem_b_next;
            root_b_reg <= root_b_next;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_a  = rem_a_reg;
    assign out_root_a = root_a_reg;
    assign out_rem_b  = rem_b_reg;
    assign out_root_b = root_b_reg;
    assign out_side   = side_reg;

endmodule : bprd_sqrt_stage
`default_nettype wire

### design/bprd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bprd_front
// Compare, union and per-axis extents, then squares and their sums, over
// three registered stages.
// ----------------------------------------------------------------------------
module bprd_front
    import bprd_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [IN_BITS-1:0]    in_data,
    output logic                       out_valid,
    output logic [SQ_SUM_BITS-1:0]     out_gap_sq,
    output logic [SQ_SUM_BITS-1:0]     out_span_sq,
    output side_t                      out_side
);

    localparam int DB = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] c [8];
    logic signed [FIELD_BITS-1:0] e [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            c[i] = in_data[i*FIELD_BITS +: COORD_BITS];
            e[i] = FIELD_BITS'(c[i]);
        end
    end

    // stage 1: relation, union, axis magnitudes
    logic           v1_reg;
    side_t          side1_reg, side1_next;
    logic [DB-1:0]  gx_reg, gy_reg, sx_reg, sy_reg;
    logic [DB-1:0]  gx_next, gy_next, sx_next, sy_next;

    always_comb
    begin
        logic signed [DB-1:0] dx, dy;
        side1_next.overlaps = !(c[4] > c[2] || c[6] < c[0] || c[5] > c[3] || c[7] < c[1]);
        side1_next.first_holds_second =
            c[4] >= c[0] && c[6] <= c[2] && c[5] >= c[1] && c[7] <= c[3];
        side1_next.union_low_x  = (c[0] < c[4]) ? e[0] : e[4];
        side1_next.union_low_y  = (c[1] < c[5]) ? e[1] : e[5];
        side1_next.union_high_x = (c[2] > c[6]) ? e[2] : e[6];
        side1_next.union_high_y = (c[3] > c[7]) ? e[3] : e[7];
        gx_next = '0;
        gy_next = '0;
        if (!side1_next.overlaps)
        begin
            if (c[5] > c[3])
                gy_next = DB'(DB'(c[5]) - DB'(c[3]));
            else if (c[7] < c[1])
                gy_next = DB'(DB'(c[1]) - DB'(c[7]));
            if (c[4] > c[2])
                gx_next = DB'(DB'(c[4]) - DB'(c[2]));
            else if (c[6] < c[0])
                gx_next = DB'(DB'(c[0]) - DB'(c[6]));
        end
        dx = DB'(side1_next.union_high_x) - DB'(side1_next.union_low_x);
        dy = DB'(side1_next.union_high_y) - DB'(side1_next.union_low_y);
        sx_next = dx[DB-1] ? DB'(-dx) : DB'(dx);
        sy_next = dy[DB-1] ? DB'(-dy) : DB'(dy);
    end

    // stage 2: squares
    logic          v2_reg;
    side_t         side2_reg;
    logic [SQ_BITS-1:0] gxx_reg, gyy_reg, sxx_reg, syy_reg;

    // stage 3: sums
    logic          v3_reg;
    side_t         side3_reg;
    logic [SQ_SUM_BITS-1:0] gsum_reg, ssum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            side2_reg <= side1_reg;
            gxx_reg   <= SQ_BITS'(gx_reg) * SQ_BITS'(gx_reg);
            gyy_reg   <= SQ_BITS'(gy_reg) * SQ_BITS'(gy_reg);
            sxx_reg   <= SQ_BITS'(sx_reg) * SQ_BITS'(sx_reg);
            syy_reg   <= SQ_BITS'(sy_reg) * SQ_BITS'(sy_reg);
            side3_reg <= side2_reg;
            gsum_reg  <= SQ_SUM_BITS'(gxx_reg) + SQ_SUM_BITS'(gyy_reg);
            ssum_reg  <= SQ_SUM_BITS'(sxx_reg) + SQ_SUM_BITS'(syy_reg);
        end
    end

    assign out_valid   = v3_reg;
    assign out_gap_sq  = gsum_reg;
    assign out_span_sq = ssum_reg;
    assign out_side    = side3_reg;

endmodule : bprd_front
`default_nettype wire

### bench/box_pair_relation_distance_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_pair_relation_distance_core_test
// Streams box pairs through the core and checks relation flags, the minimum
// gap, the union diagonal and the union box against a local predictor.
// ----------------------------------------------------------------------------
module box_pair_relation_distance_core_test;
    import bprd_pkg::*;

    localparam int RANDOM_PAIRS = 600;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic                  overlaps;
        logic                  first_holds_second;
        logic [DIST_BITS-1:0]  min_gap;
        logic [DIST_BITS-1:0]  max_span;
        logic [31:0]           union_low_x;
        logic [31:0]           union_low_y;
        logic [31:0]           union_high_x;
        logic [31:0]           union_high_y;
    } relation_t;

    typedef struct {
        logic [31:0] c [8];
        logic        known;
        relation_t   res;
    } pair_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_BITS-1:0]        s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    relation_t  pending_relations [$];
    pair_row_t  pair_table [$];
    int         fail_count;
    int         idle_cycles;
    int         beats_in;
    int         beats_out;
    int         overlap_seen;
    int         apart_seen;
    logic       calm;

    box_pair_relation_distance_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [DIST_BITS-1:0] root_of_squares(logic [DIST_BITS-1:0] a,
                                                             logic [DIST_BITS-1:0] b);
        logic [SQ_SUM_BITS-1:0] total;
        logic [SQ_SUM_BITS-1:0] trial;
        logic [DIST_BITS-1:0]   r;
        logic [DIST_BITS-1:0]   c;
        total = SQ_SUM_BITS'(a) * SQ_SUM_BITS'(a) + SQ_SUM_BITS'(b) * SQ_SUM_BITS'(b);
        r = '0;
        for (int k = DIST_BITS - 1; k >= 0; k--)
        begin
            c = r | (DIST_BITS'(1) << k);
            trial = SQ_SUM_BITS'(c) * SQ_SUM_BITS'(c);
            if (trial <= total)
                r = c;
        end
        return r;
    endfunction

    function automatic relation_t predict_relation(logic [31:0] c [8]);
        longint v [8];
        longint sx;
        longint sy;
        longint ulx;
        longint uly;
        longint uhx;
        longint uhy;
        longint ex;
        longint ey;
        relation_t r;
        for (int i = 0; i < 8; i++)
            v[i] = longint'($signed(c[i]));
        sx = 0;
        sy = 0;
        r.overlaps = !(v[4] > v[2] || v[6] < v[0] || v[5] > v[3] || v[7] < v[1]);
        r.first_holds_second = v[4] >= v[0] && v[6] <= v[2] && v[5] >= v[1] && v[7] <= v[3];
        r.min_gap = '0;
        if (!r.overlaps)
        begin
            if (v[5] > v[3])
                sy = v[5] - v[3];
            else if (v[7] < v[1])
                sy = v[1] - v[7];
            if (v[4] > v[2])
                sx = v[4] - v[2];
            else if (v[6] < v[0])
                sx = v[0] - v[6];
            r.min_gap = root_of_squares(DIST_BITS'(sx), DIST_BITS'(sy));
        end
        ulx = v[0] < v[4] ? v[0] : v[4];
        uly = v[1] < v[5] ? v[1] : v[5];
        uhx = v[2] > v[6] ? v[2] : v[6];
        uhy = v[3] > v[7] ? v[3] : v[7];
        ex = uhx - ulx;
        ey = uhy - uly;
        if (ex < 0)
            ex = -ex;
        if (ey < 0)
            ey = -ey;
        r.max_span = root_of_squares(DIST_BITS'(ex), DIST_BITS'(ey));
        r.union_low_x = ulx[31:0];
        r.union_low_y = uly[31:0];
        r.union_high_x = uhx[31:0];
        r.union_high_y = uhy[31:0];
        return r;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
        endcase
    endfunction

    // build a pair: mostly well-formed boxes, some inverted or fully random
    function automatic void random_pair(output logic [31:0] c [8]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
            c[i] = random_coord();
        if (mode < 8)
        begin
            for (int b = 0; b < 8; b += 4)
                for (int a = 0; a < 2; a++)
                    if ($signed(c[b + a]) > $signed(c[b + a + 2]))
                    begin
                        logic [31:0] t;
                        t = c[b + a];
                        c[b + a] = c[b + a + 2];
                        c[b + a + 2] = t;
                    end
            if (mode < 2)
            begin
                // shrink the second box into the first
                c[4] = c[0] + (($signed(c[2]) - $signed(c[0])) >>> 2);
                c[5] = c[1] + (($signed(c[3]) - $signed(c[1])) >>> 2);
                c[6] = c[2];
                c[7] = c[3];
            end
            else if (mode == 2)
            begin
                // touching edge
                c[4] = c[2];
            end
        end
    endfunction

    task automatic send_pair(logic [31:0] c [8]);
        while (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        for (int i = 0; i < 8; i++)
            s_axis_tdata[i*32 +: 32] <= c[i];
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_relations.push_back(predict_relation(c));
        beats_in++;
        @(negedge clk);
    endtask

    function automatic void add_row(logic [31:0] c [8], logic known, relation_t res);
        pair_row_t row;
        row.c = c;
        row.known = known;
        row.res = res;
        pair_table.push_back(row);
    endfunction

    task automatic build_table();
        logic [31:0] c [8];
        relation_t r;
        // identical unit boxes at origin
        c = '{0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000};
        r = '{1'b1, 1'b1, 33'd0, 33'd92681, 0, 0, 32'h10000, 32'h10000};
        add_row(c, 1'b1, r);
        // gap of 3,4 units gives 5
        c = '{0, 0, 0, 0, 32'h30000, 32'h40000, 32'h30000, 32'h40000};
        r = '{1'b0, 1'b0, 33'h50000, 33'h50000, 0, 0, 32'h30000, 32'h40000};
        add_row(c, 1'b1, r);
        // full-range extremes both ways
        c = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        r = '{1'b1, 1'b1, 33'd0, 33'd6074000998, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF};
        add_row(c, 1'b1, r);
        c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        add_row(c, 1'b0, r);
        // touching edges
        c = '{0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000};
        add_row(c, 1'b0, r);
        // inverted boxes
        c = '{32'h10000, 32'h10000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000};
        add_row(c, 1'b0, r);
        c = '{32'h50000, 32'h50000, 32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 0, 0};
        add_row(c, 1'b0, r);
        // all ones / separated boxes
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        add_row(c, 1'b0, r);
        c = '{32'h20000, 32'h20000, 32'h30000, 32'h30000, 0, 0, 32'h10000, 32'h10000};
        add_row(c, 1'b0, r);
        c = '{0, 32'h20000, 32'h10000, 32'h30000, 0, 0, 32'h10000, 32'h10000};
        add_row(c, 1'b0, r);
        c = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        add_row(c, 1'b0, r);
    endtask

    // result side: random stalls, drained by the checker
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 7) == 0)
            m_axis_tready <= 1'b0;
        else if (!m_axis_tready && $urandom_range(0, 3) == 0)
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        relation_t got;
        relation_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2 +: 33],
                   m_axis_tdata[35 +: 33], m_axis_tdata[68 +: 32], m_axis_tdata[100 +: 32],
                   m_axis_tdata[132 +: 32], m_axis_tdata[164 +: 32]};
            beats_out++;
            if (pending_relations.size() == 0)
            begin
                $error("result beat with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_relations.pop_front();
                if (got.overlaps) overlap_seen++; else apart_seen++;
                if (got.overlaps !== want.overlaps)
                begin
                    $error("overlaps exp %0d got %0d", want.overlaps, got.overlaps);
                    fail_count++;
                end
                if (got.first_holds_second !== want.first_holds_second)
                begin
                    $error("first_holds_second exp %0d got %0d",
                           want.first_holds_second, got.first_holds_second);
                    fail_count++;
                end
                if (got.min_gap !== want.min_gap)
                begin
                    $error("min_gap exp %0d got %0d", want.min_gap, got.min_gap);
                    fail_count++;
                end
                if (got.max_span !== want.max_span)
                begin
                    $error("max_span exp %0d got %0d", want.max_span, got.max_span);
                    fail_count++;
                end
                if (got.union_low_x !== want.union_low_x)
                begin
                    $error("union_low_x exp %h got %h", want.union_low_x, got.union_low_x);
                    fail_count++;
                end
                if (got.union_low_y !== want.union_low_y)
                begin
                    $error("union_low_y exp %h got %h", want.union_low_y, got.union_low_y);
                    fail_count++;
                end
                if (got.union_high_x !== want.union_high_x)
                begin
                    $error("union_high_x exp %h got %h", want.union_high_x, got.union_high_x);
                    fail_count++;
                end
                if (got.union_high_y !== want.union_high_y)
                begin
                    $error("union_high_y exp %h got %h", want.union_high_y, got.union_high_y);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] c [8];
        relation_t want;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        fail_count = 0;
        idle_cycles = 0;
        beats_in = 0;
        beats_out = 0;
        overlap_seen = 0;
        apart_seen = 0;
        calm = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        build_table();
        foreach (pair_table[i])
        begin
            if (pair_table[i].known)
            begin
                want = predict_relation(pair_table[i].c);
                if (want !== pair_table[i].res)
                begin
                    $error("table row %0d: predictor disagrees with typed result", i);
                    fail_count++;
                end
            end
            send_pair(pair_table[i].c);
        end

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            if (n == RANDOM_PAIRS - 100)
                calm = 1'b1;
            random_pair(c);
            send_pair(c);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_relations.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d box pairs, checked %0d results (%0d overlapping, %0d apart).",
                 beats_in, beats_out, overlap_seen, apart_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
